[sv/dwr_pkg.sv]
// ---------------------------------------------------------------------------
// dwr_pkg
// shared types and constants for the double-ended queue with reversal
// ---------------------------------------------------------------------------
package dwr_pkg;

  localparam int OP_BITS          = 3;
  localparam int VALUE_BITS       = 64;
  localparam int STATUS_BITS      = 2;
  localparam int COUNT_BITS       = 5;
  localparam int DEF_CAPACITY     = 16;
  localparam int DEF_WORD_BITS    = 64;

  typedef enum logic [OP_BITS-1:0] {
    OP_ADD_FRONT    = 3'd0,
    OP_ADD_BACK     = 3'd1,
    OP_REMOVE_FRONT = 3'd2,
    OP_REMOVE_BACK  = 3'd3,
    OP_REVERSE      = 3'd4
  } op_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // what a row of cells does in one cycle
  typedef enum logic [1:0] {
    ROW_HOLD       = 2'd0,
    ROW_SHIFT_UP   = 2'd1,
    ROW_SHIFT_DOWN = 2'd2,
    ROW_LOAD_AT    = 2'd3
  } row_op_t;

endpackage

[sv/deque_with_reverse.sv]
// ---------------------------------------------------------------------------
// deque_with_reverse
// bounded double-ended queue of words with constant-time order reversal
// ---------------------------------------------------------------------------
// One transaction is taken per clock cycle; each gives one result, shown the
// cycle after acceptance and held until taken because the state only moves on
// acceptance, so the input stalls only while a result waits under out_stall.
// Words live in two rows of CAPACITY cells, one keeping the physical front in
// its cell 0, the other the physical back; an add shifts one row and loads a
// cell of the other, a remove shifts only its own end's row, so both ends are
// always read at fixed cells. Reverse flips a direction flag swapping the ends.
// Adds to a full queue are rejected as full, removes and reverses on an empty
// queue as empty, and front and back read as zero when the queue is empty.
module deque_with_reverse #(
  parameter int CAPACITY  = dwr_pkg::DEF_CAPACITY,
  parameter int WORD_BITS = dwr_pkg::DEF_WORD_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [dwr_pkg::OP_BITS-1:0]     in_operation,
  input  logic [dwr_pkg::VALUE_BITS-1:0]  in_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [dwr_pkg::STATUS_BITS-1:0] out_status,
  output logic [dwr_pkg::VALUE_BITS-1:0]  out_front_value,
  output logic [dwr_pkg::VALUE_BITS-1:0]  out_back_value,
  output logic [dwr_pkg::COUNT_BITS-1:0]  out_count,
  output logic                            out_is_empty
);
  import dwr_pkg::*;

  localparam int CNT_BITS = $clog2(CAPACITY + 1);
  localparam int IDX_BITS = $clog2(CAPACITY);

  logic [CNT_BITS-1:0] occ_r, occ_nxt;
  logic                rev_r, rev_nxt;
  logic                out_valid_r, out_valid_nxt;
  status_t             status_r, status_nxt;

  logic                in_acc;
  op_t                 op;
  logic                full, empty;
  logic                push_pf, push_pb, pop_pf, pop_pb;
  row_op_t             front_row_op, back_row_op;
  logic [IDX_BITS-1:0] load_pos;
  logic [WORD_BITS-1:0] word_in;
  logic [WORD_BITS-1:0] front_head, back_head;

  assign in_stall = out_valid_r & out_stall;
  assign in_acc   = in_valid & ~in_stall;
  assign op       = op_t'(in_operation);
  assign full     = (occ_r == CNT_BITS'(CAPACITY));
  assign empty    = (occ_r == '0);
  assign word_in  = in_value[WORD_BITS-1:0];
  // a load only happens below capacity, so the count fits an index
  assign load_pos = occ_r[IDX_BITS-1:0];

  // operation decode into physical-end moves
  always_comb begin
    status_nxt = ST_DONE;
    push_pf    = 1'b0;
    push_pb    = 1'b0;
    pop_pf     = 1'b0;
    pop_pb     = 1'b0;
    rev_nxt    = rev_r;
    unique case (op) inside
      OP_ADD_FRONT, OP_ADD_BACK: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else if ((op == OP_ADD_FRONT) != rev_r) begin
          push_pf = in_acc;
        end else begin
          push_pb = in_acc;
        end
      end
      OP_REMOVE_FRONT, OP_REMOVE_BACK: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else if ((op == OP_REMOVE_FRONT) != rev_r) begin
          pop_pf = in_acc;
        end else begin
          pop_pb = in_acc;
        end
      end
      OP_REVERSE: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else if (in_acc) begin
          rev_nxt = ~rev_r;
        end
      end
      default: status_nxt = ST_DONE;
    endcase
  end

  always_comb begin
    occ_nxt = occ_r;
    if (push_pf || push_pb) occ_nxt = occ_r + CNT_BITS'(1);
    else if (pop_pf || pop_pb) occ_nxt = occ_r - CNT_BITS'(1);
  end

  // row commands: each row treats its own end as cell 0
  always_comb begin
    front_row_op = ROW_HOLD;
    back_row_op  = ROW_HOLD;
    if (push_pf) begin
      front_row_op = ROW_SHIFT_UP;
      back_row_op  = ROW_LOAD_AT;
    end else if (push_pb) begin
      front_row_op = ROW_LOAD_AT;
      back_row_op  = ROW_SHIFT_UP;
    end else if (pop_pf) begin
      front_row_op = ROW_SHIFT_DOWN;
    end else if (pop_pb) begin
      back_row_op  = ROW_SHIFT_DOWN;
    end
  end

  dwr_row #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS),
    .IDX_BITS  (IDX_BITS)
  ) u_front_row (
    .clk       (clk),
    .op        (front_row_op),
    .load_pos  (load_pos),
    .load_word (word_in),
    .head_word (front_head)
  );

  dwr_row #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS),
    .IDX_BITS  (IDX_BITS)
  ) u_back_row (
    .clk       (clk),
    .op        (back_row_op),
    .load_pos  (load_pos),
    .load_word (word_in),
    .head_word (back_head)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      rev_r       <= 1'b0;
      out_valid_r <= 1'b0;
      status_r    <= ST_DONE;
    end else begin
      occ_r       <= occ_nxt;
      rev_r       <= rev_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_acc) status_r <= status_nxt;
    end
  end

  // state only moves on acceptance, so these hold while the result waits
  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_front_value = empty ? '0 : VALUE_BITS'(rev_r ? back_head : front_head);
  assign out_back_value  = empty ? '0 : VALUE_BITS'(rev_r ? front_head : back_head);
  assign out_count       = COUNT_BITS'(occ_r);
  assign out_is_empty    = empty;

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_BITS'(CAPACITY))
    else $error("occupancy above capacity");

  a_add_counts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (op == OP_ADD_FRONT || op == OP_ADD_BACK) && !full
    |=> occ_r == $past(occ_r) + CNT_BITS'(1))
    else $error("accepted add did not raise the count");

  a_reject_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && status_nxt != ST_DONE |=> $stable(occ_r) && $stable(rev_r))
    else $error("rejected transaction changed the state");

  a_reverse_flips: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && op == OP_REVERSE && !empty |=> rev_r != $past(rev_r))
    else $error("reverse did not flip the direction");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted transaction gave no result");
`endif

endmodule

[sv/dwr_cell.sv]
// ---------------------------------------------------------------------------
// dwr_cell
// one storage cell of a row: holds a word, takes it from a neighbor on a
// shift or from the input word when the load position matches its own
// ---------------------------------------------------------------------------
module dwr_cell #(
  parameter int IDX       = 0,
  parameter int IDX_BITS  = 4,
  parameter int WORD_BITS = 64
) (
  input  logic                 clk,
  input  dwr_pkg::row_op_t     op,
  input  logic [IDX_BITS-1:0]  load_pos,
  input  logic [WORD_BITS-1:0] load_word,
  input  logic [WORD_BITS-1:0] lower_word,
  input  logic [WORD_BITS-1:0] upper_word,
  output logic [WORD_BITS-1:0] word
);
  import dwr_pkg::*;

  logic [WORD_BITS-1:0] word_r;
  logic [WORD_BITS-1:0] word_nxt;

  always_comb begin
    word_nxt = word_r;
    case (op)
      ROW_SHIFT_UP:   word_nxt = lower_word;
      ROW_SHIFT_DOWN: word_nxt = upper_word;
      ROW_LOAD_AT: begin
        if (load_pos == IDX_BITS'(IDX)) word_nxt = load_word;
      end
      default:        word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule

[sv/dwr_row.sv]
// ---------------------------------------------------------------------------
// dwr_row
// chain of cells with one end fixed at cell 0; shift up inserts at cell 0,
// shift down drops cell 0, load writes the cell just past the last word
// ---------------------------------------------------------------------------
module dwr_row #(
  parameter int CAPACITY  = 16,
  parameter int WORD_BITS = 64,
  parameter int IDX_BITS  = 4
) (
  input  logic                 clk,
  input  dwr_pkg::row_op_t     op,
  input  logic [IDX_BITS-1:0]  load_pos,
  input  logic [WORD_BITS-1:0] load_word,
  output logic [WORD_BITS-1:0] head_word
);
  import dwr_pkg::*;

  logic [WORD_BITS-1:0] cell_word [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_BITS-1:0] lower;
    logic [WORD_BITS-1:0] upper;

    if (i == 0) begin : g_first
      assign lower = load_word;
    end else begin : g_mid_lo
      assign lower = cell_word[i-1];
    end

    // the top cell gets a don't-care word on a shift down, never read
    if (i == CAPACITY - 1) begin : g_last
      assign upper = load_word;
    end else begin : g_mid_hi
      assign upper = cell_word[i+1];
    end

    dwr_cell #(
      .IDX       (i),
      .IDX_BITS  (IDX_BITS),
      .WORD_BITS (WORD_BITS)
    ) u_cell (
      .clk        (clk),
      .op         (op),
      .load_pos   (load_pos),
      .load_word  (load_word),
      .lower_word (lower),
      .upper_word (upper),
      .word       (cell_word[i])
    );
  end

  assign head_word = cell_word[0];

endmodule

[dv/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top
// self-checking testbench for the double-ended queue with order reversal
// ---------------------------------------------------------------------------
// A short table of directed transactions (empty and full rejections, spare
// opcodes, word extremes, reversal of a single word) is followed by about a
// thousand random transactions that drift between filling and draining, so
// the queue spends time near both ends. A behavioral copy of the queue works
// out each expected result. Both sides idle at random, and once the result
// side holds off long enough for the input to back up.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dwr_pkg::*;

  localparam int CAP          = DEF_CAPACITY;
  localparam int WB           = DEF_WORD_BITS;
  localparam int RANDOM_ITEMS = 1020;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_AT      = 250;
  localparam int HOLD_CYCLES  = 60;

  // opcodes the block treats as no-ops
  localparam logic [OP_BITS-1:0] OP_SPARE_LO  = 3'd5;
  localparam logic [OP_BITS-1:0] OP_SPARE_MID = 3'd6;
  localparam logic [OP_BITS-1:0] OP_SPARE_HI  = 3'd7;

  localparam logic [VALUE_BITS-1:0] ALL_ONES  = '1;
  localparam logic [VALUE_BITS-1:0] FILL_WORD = 64'h0123_4567_89ab_cdef;
  localparam logic [VALUE_BITS-1:0] WORD_MASK =
    (WB >= VALUE_BITS) ? ALL_ONES : ((64'd1 << WB) - 64'd1);

  typedef struct packed {
    status_t                 status;
    logic [VALUE_BITS-1:0]   front;
    logic [VALUE_BITS-1:0]   back;
    logic [COUNT_BITS-1:0]   count;
    logic                    is_empty;
  } deque_view_t;

  typedef struct {
    logic [OP_BITS-1:0]    op;
    logic [VALUE_BITS-1:0] value;
    int                    reps;
    bit                    typed;
    deque_view_t           want;
  } stim_row_t;

  localparam deque_view_t NO_VIEW    = '0;
  localparam deque_view_t EMPTY_REJ  = '{ST_EMPTY, 64'd0, 64'd0, 5'd0, 1'b1};
  localparam deque_view_t EMPTY_IDLE = '{ST_DONE, 64'd0, 64'd0, 5'd0, 1'b1};
  localparam deque_view_t FULL_REJ   = '{ST_FULL, 64'd0, FILL_WORD, 5'd16, 1'b0};

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [OP_BITS-1:0]      in_operation = '0;
  logic [VALUE_BITS-1:0]   in_value = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [STATUS_BITS-1:0]  out_status;
  logic [VALUE_BITS-1:0]   out_front_value;
  logic [VALUE_BITS-1:0]   out_back_value;
  logic [COUNT_BITS-1:0]   out_count;
  logic                    out_is_empty;

  // behavioral copy of the queue
  logic [VALUE_BITS-1:0]   ring_words [CAP];
  int                      ring_head = 0;
  int                      ring_held = 0;
  bit                      ring_flipped = 1'b0;

  deque_view_t             pending_views [$];
  stim_row_t               directed_rows [$];
  bit                      steady = 1'b0;
  int                      errors = 0;
  int                      items_sent = 0;
  int                      results_seen = 0;
  int                      full_rejects = 0;
  int                      empty_rejects = 0;
  int                      flips = 0;
  int                      peak_held = 0;
  int                      cycle_count = 0;

  deque_with_reverse #(
    .CAPACITY  (CAP),
    .WORD_BITS (WB)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_front_value (out_front_value),
    .out_back_value  (out_back_value),
    .out_count       (out_count),
    .out_is_empty    (out_is_empty)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic deque_view_t apply_op(logic [OP_BITS-1:0] op,
                                           logic [VALUE_BITS-1:0] value);
    deque_view_t view;
    bit          phys_front;
    logic [VALUE_BITS-1:0] pf;
    logic [VALUE_BITS-1:0] pb;
    view = '0;
    view.status = ST_DONE;
    case (op) inside
      OP_ADD_FRONT, OP_ADD_BACK: begin
        if (ring_held == CAP) begin
          view.status = ST_FULL;
          full_rejects++;
        end else begin
          phys_front = (op == OP_ADD_FRONT) != ring_flipped;
          if (phys_front) begin
            ring_head = (ring_head + CAP - 1) % CAP;
            ring_words[ring_head] = value & WORD_MASK;
          end else begin
            ring_words[(ring_head + ring_held) % CAP] = value & WORD_MASK;
          end
          ring_held++;
        end
      end
      OP_REMOVE_FRONT, OP_REMOVE_BACK: begin
        if (ring_held == 0) begin
          view.status = ST_EMPTY;
          empty_rejects++;
        end else begin
          phys_front = (op == OP_REMOVE_FRONT) != ring_flipped;
          if (phys_front) ring_head = (ring_head + 1) % CAP;
          ring_held--;
        end
      end
      OP_REVERSE: begin
        if (ring_held == 0) begin
          view.status = ST_EMPTY;
          empty_rejects++;
        end else begin
          ring_flipped = !ring_flipped;
          flips++;
        end
      end
      default: ;
    endcase
    if (ring_held != 0) begin
      pf = ring_words[ring_head];
      pb = ring_words[(ring_head + ring_held - 1) % CAP];
      view.front = ring_flipped ? pb : pf;
      view.back  = ring_flipped ? pf : pb;
    end
    view.count    = ring_held[COUNT_BITS-1:0];
    view.is_empty = (ring_held == 0);
    if (ring_held > peak_held) peak_held = ring_held;
    return view;
  endfunction

  task automatic add_row(logic [OP_BITS-1:0] op, logic [VALUE_BITS-1:0] value,
                         int reps, bit typed, deque_view_t want);
    stim_row_t row;
    row.op    = op;
    row.value = value;
    row.reps  = reps;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  // holds the transaction until taken, then maybe leaves a gap
  task automatic send_item(logic [OP_BITS-1:0] op, logic [VALUE_BITS-1:0] value,
                           deque_view_t want);
    in_valid     <= 1'b1;
    in_operation <= op;
    in_value     <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_views.push_back(want);
    items_sent++;
    // after about one transaction in five, a random gap leaves the input idle
    if (!steady && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  task automatic check_field(string field, logic [VALUE_BITS-1:0] want,
                             logic [VALUE_BITS-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
    end
  endtask

  // result side: check, then decide the stall for the next cycle
  initial begin
    deque_view_t want;
    int          hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        results_seen++;
        if (pending_views.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, status %0d count %0d",
                   $time, out_status, out_count);
        end else begin
          want = pending_views.pop_front();
          check_field("status", want.status, out_status);
          check_field("front_value", want.front, out_front_value);
          check_field("back_value", want.back, out_back_value);
          check_field("count", want.count, out_count);
          check_field("is_empty", want.is_empty, out_is_empty);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      out_stall <= (hold_left > 0) || (!steady && $urandom_range(99) < 31);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: run timed out with %0d results outstanding", $time, pending_views.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    stim_row_t             row;
    deque_view_t           want;
    logic [OP_BITS-1:0]    op;
    logic [VALUE_BITS-1:0] value;
    int                    mode;
    int                    pick;
    int                    add_share;

    add_row(OP_REMOVE_FRONT, 64'd0, 1, 1'b1, EMPTY_REJ);
    add_row(OP_REMOVE_BACK, ALL_ONES, 1, 1'b1, EMPTY_REJ);
    add_row(OP_REVERSE, 64'd0, 1, 1'b1, EMPTY_REJ);
    add_row(OP_SPARE_LO, ALL_ONES, 1, 1'b1, EMPTY_IDLE);
    add_row(OP_SPARE_HI, 64'd0, 1, 1'b1, EMPTY_IDLE);
    add_row(OP_ADD_BACK, ALL_ONES, 1, 1'b1, '{ST_DONE, ALL_ONES, ALL_ONES, 5'd1, 1'b0});
    add_row(OP_REMOVE_FRONT, 64'd0, 1, 1'b1, EMPTY_IDLE);
    add_row(OP_ADD_FRONT, 64'd0, 1, 1'b1, '{ST_DONE, 64'd0, 64'd0, 5'd1, 1'b0});
    add_row(OP_REVERSE, 64'd0, 1, 1'b1, '{ST_DONE, 64'd0, 64'd0, 5'd1, 1'b0});
    add_row(OP_ADD_BACK, FILL_WORD, CAP - 1, 1'b0, NO_VIEW);
    add_row(OP_ADD_BACK, ALL_ONES, 1, 1'b1, FULL_REJ);
    add_row(OP_ADD_FRONT, ALL_ONES, 1, 1'b1, FULL_REJ);
    add_row(OP_SPARE_MID, ALL_ONES, 1, 1'b0, NO_VIEW);
    add_row(OP_REVERSE, 64'd0, 1, 1'b0, NO_VIEW);
    add_row(OP_REMOVE_FRONT, 64'd0, 1, 1'b0, NO_VIEW);
    add_row(OP_REMOVE_BACK, 64'd0, 1, 1'b0, NO_VIEW);
    add_row(OP_ADD_FRONT, ALL_ONES, 1, 1'b0, NO_VIEW);
    add_row(OP_REVERSE, 64'd0, 1, 1'b0, NO_VIEW);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      repeat (row.reps) begin
        want = apply_op(row.op, row.value);
        send_item(row.op, row.value, row.typed ? row.want : want);
      end
    end

    // blocks of fill-heavy, drain-heavy and balanced traffic
    mode = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) mode = $urandom_range(2);
      steady = (n >= 500 && n < 700);
      case (mode)
        0:       add_share = 62;
        1:       add_share = 22;
        default: add_share = 44;
      endcase
      pick = $urandom_range(99);
      if (pick < 3)
        op = OP_SPARE_LO + OP_BITS'($urandom_range(2));
      else if (pick < 11)
        op = OP_REVERSE;
      else if (pick < 11 + add_share)
        op = $urandom_range(1) ? OP_ADD_FRONT : OP_ADD_BACK;
      else
        op = $urandom_range(1) ? OP_REMOVE_FRONT : OP_REMOVE_BACK;
      case ($urandom_range(7))
        0:       value = 64'd0;
        1:       value = ALL_ONES;
        2:       value = 64'd1 << $urandom_range(63);
        default: value = {$urandom, $urandom};
      endcase
      want = apply_op(op, value);
      send_item(op, value, want);
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    while (pending_views.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Ran %0d transactions, %0d results checked, peak occupancy %0d of %0d",
             items_sent, results_seen, peak_held, CAP);
    $display("Saw %0d full rejections, %0d empty rejections and %0d reversals",
             full_rejects, empty_rejects, flips);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
